// ----- hdl/keyword_token_lexer_macros.svh -----
// Assertion macros for the keyword token lexer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef KEYWORD_TOKEN_LEXER_MACROS_SVH
`define KEYWORD_TOKEN_LEXER_MACROS_SVH

// same-cycle implication
`define KTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/klt_pkg.sv -----
// Shared types and constants for the keyword token lexer.
// No dependencies; imported by every module of the block.
package klt_pkg;

  typedef enum logic [3:0] {
    KIND_IDENT  = 4'd0,
    KIND_DEF    = 4'd1,
    KIND_EXTERN = 4'd2,
    KIND_NUMBER = 4'd3,
    KIND_LPAREN = 4'd4,
    KIND_RPAREN = 4'd5,
    KIND_PLUS   = 4'd6,
    KIND_MINUS  = 4'd7,
    KIND_STAR   = 4'd8,
    KIND_COMMA  = 4'd9,
    KIND_DOT    = 4'd10,
    KIND_EOF    = 4'd11,
    KIND_ERROR  = 4'd12
  } token_kind_e;

  typedef enum logic [2:0] {
    CLS_SPACE = 3'd0,
    CLS_ALPHA = 3'd1,
    CLS_DIGIT = 3'd2,
    CLS_PUNCT = 3'd3,
    CLS_BAD   = 3'd4
  } char_class_e;

  // classified request handed from front to back
  typedef struct packed {
    logic        command;
    logic [7:0]  source_byte;
    char_class_e cls;
    token_kind_e punct_kind;
  } front_item_t;

  typedef struct packed {
    token_kind_e kind;
    logic [31:0] start;
    logic [15:0] len;
    logic [7:0]  bad;
    logic        last;
  } result_t;

  // zero, one or two results written together, first is older
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_wr_t;

  localparam logic       CMD_END       = 1'b1;
  localparam int unsigned IN_DEPTH_DEF  = 4;
  localparam int unsigned OUT_DEPTH_DEF = 4;

endpackage

// ----- hdl/klt_front.sv -----
// Front end: classifies each incoming byte and queues it for the scanner.
// Depends on klt_pkg; IN_DEPTH is a power of two, at least 2.
module klt_front
  import klt_pkg::*;
#(
  parameter int unsigned IN_DEPTH = IN_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        command_i,
  input  logic [7:0]  source_byte_i,
  output logic        head_valid_o,
  output front_item_t head_o,
  input  logic        head_pop_i
);

  localparam int unsigned PW = $clog2(IN_DEPTH);
  localparam int unsigned CW = $clog2(IN_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(IN_DEPTH);

  front_item_t       mem [IN_DEPTH];
  front_item_t       item;
  logic [PW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic              wr_en, rd_en;

  always_comb begin
    item.command     = command_i;
    item.source_byte = source_byte_i;
    item.punct_kind  = KIND_ERROR;
    item.cls         = CLS_BAD;
    unique case (source_byte_i)
      8'h28: item.punct_kind = KIND_LPAREN;
      8'h29: item.punct_kind = KIND_RPAREN;
      8'h2B: item.punct_kind = KIND_PLUS;
      8'h2D: item.punct_kind = KIND_MINUS;
      8'h2A: item.punct_kind = KIND_STAR;
      8'h2C: item.punct_kind = KIND_COMMA;
      8'h2E: item.punct_kind = KIND_DOT;
      default: item.punct_kind = KIND_ERROR;
    endcase
    priority if (source_byte_i == 8'h20 ||
                 (source_byte_i >= 8'h09 && source_byte_i <= 8'h0D)) begin
      item.cls = CLS_SPACE;
    end else if ((source_byte_i >= 8'h41 && source_byte_i <= 8'h5A) ||
                 (source_byte_i >= 8'h61 && source_byte_i <= 8'h7A)) begin
      item.cls = CLS_ALPHA;
    end else if (source_byte_i >= 8'h30 && source_byte_i <= 8'h39) begin
      item.cls = CLS_DIGIT;
    end else if (item.punct_kind != KIND_ERROR) begin
      item.cls = CLS_PUNCT;
    end else begin
      item.cls = CLS_BAD;
    end
  end

  assign full         = (count_q == DEPTH_C);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem[rptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = head_pop_i && head_valid_o;

  always_comb begin
    wptr_d  = wr_en ? wptr_q + PW'(1) : wptr_q;
    rptr_d  = rd_en ? rptr_q + PW'(1) : rptr_q;
    count_d = count_q + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wptr_q] <= item;
    end
  end

endmodule

// ----- hdl/klt_back.sv -----
// Back end: token scanner state machine, one queued request per cycle while
// the result queue has room. Depends on klt_pkg; writes up to two results per request.
module klt_back
  import klt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  front_item_t head_i,
  output logic        head_pop_o,
  input  logic        out_space_i,
  output result_wr_t  res_wr_o
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_ERROR  = 2'd3;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam logic [7:0]  CH_D = 8'h64;
  localparam logic [7:0]  CH_E = 8'h65;
  localparam logic [7:0]  CH_F = 8'h66;
  localparam logic [7:0]  CH_X = 8'h78;
  localparam logic [7:0]  CH_T = 8'h74;
  localparam logic [7:0]  CH_R = 8'h72;
  localparam logic [7:0]  CH_N = 8'h6E;

  function automatic logic [7:0] def_char(input logic [1:0] idx);
    unique case (idx)
      2'd0:    def_char = CH_D;
      2'd1:    def_char = CH_E;
      default: def_char = CH_F;
    endcase
  endfunction

  function automatic logic [7:0] ext_char(input logic [2:0] idx);
    unique case (idx)
      3'd0:    ext_char = CH_E;
      3'd1:    ext_char = CH_X;
      3'd2:    ext_char = CH_T;
      3'd3:    ext_char = CH_E;
      3'd4:    ext_char = CH_R;
      default: ext_char = CH_N;
    endcase
  endfunction

  logic [1:0]  mode_q, mode_d;
  logic [31:0] start_q, start_d;
  logic [15:0] cnt_q, cnt_d;
  logic        def_q, def_d, ext_q, ext_d;
  logic [31:0] pos_q, pos_d;
  logic [7:0]  bad_q, bad_d;

  logic        fire;
  logic        flush_v, emit_v;
  result_t     flush_r, emit_r;
  token_kind_e flush_kind;
  logic [15:0] cnt_inc;
  logic        in_token;
  logic [7:0]  b;

  assign fire       = head_valid_i && out_space_i;
  assign head_pop_o = fire;
  assign b          = head_i.source_byte;
  assign in_token   = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);
  assign cnt_inc    = (cnt_q == LEN_MAX) ? cnt_q : cnt_q + 16'd1;

  always_comb begin
    priority if (mode_q != MODE_IDENT) begin
      flush_kind = KIND_NUMBER;
    end else if (def_q && cnt_q == 16'd3) begin
      flush_kind = KIND_DEF;
    end else if (ext_q && cnt_q == 16'd6) begin
      flush_kind = KIND_EXTERN;
    end else begin
      flush_kind = KIND_IDENT;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    cnt_d   = cnt_q;
    def_d   = def_q;
    ext_d   = ext_q;
    pos_d   = pos_q;
    bad_d   = bad_q;
    flush_v = 1'b0;
    emit_v  = 1'b0;
    flush_r = '{kind: flush_kind, start: start_q, len: cnt_q, bad: 8'd0, last: 1'b0};
    emit_r  = '{kind: KIND_EOF, start: pos_q, len: 16'd0, bad: 8'd0, last: 1'b1};
    if (fire) begin
      if (head_i.command == CMD_END) begin
        if (mode_q == MODE_ERROR) begin
          // sticky error replaces eof
          emit_v = 1'b1;
          emit_r = '{kind: KIND_ERROR, start: start_q, len: 16'd1, bad: bad_q, last: 1'b1};
        end else begin
          flush_v = in_token;
          emit_v  = 1'b1;
        end
        mode_d  = MODE_IDLE;
        start_d = '0;
        cnt_d   = '0;
        def_d   = 1'b1;
        ext_d   = 1'b1;
        pos_d   = '0;
        bad_d   = '0;
      end else begin
        pos_d = pos_q + 32'd1;
        priority if (mode_q == MODE_ERROR) begin
          mode_d = MODE_ERROR;
        end else if (mode_q == MODE_IDENT &&
                     (head_i.cls == CLS_ALPHA || head_i.cls == CLS_DIGIT)) begin
          def_d = def_q && (cnt_q < 16'd3) && (b == def_char(cnt_q[1:0]));
          ext_d = ext_q && (cnt_q < 16'd6) && (b == ext_char(cnt_q[2:0]));
          cnt_d = cnt_inc;
        end else if (mode_q == MODE_NUMBER && head_i.cls == CLS_DIGIT) begin
          cnt_d = cnt_inc;
        end else begin
          // byte ends any pending token, then is scanned from idle
          flush_v = in_token;
          mode_d  = MODE_IDLE;
          unique case (head_i.cls)
            CLS_SPACE: begin
              mode_d = MODE_IDLE;
            end
            CLS_ALPHA, CLS_DIGIT: begin
              mode_d  = (head_i.cls == CLS_ALPHA) ? MODE_IDENT : MODE_NUMBER;
              start_d = pos_q;
              cnt_d   = 16'd1;
              def_d   = (b == CH_D);
              ext_d   = (b == CH_E);
            end
            CLS_PUNCT: begin
              emit_v = 1'b1;
              emit_r = '{kind: head_i.punct_kind, start: pos_q, len: 16'd1, bad: 8'd0,
                         last: 1'b1};
            end
            default: begin
              mode_d  = MODE_ERROR;
              bad_d   = b;
              start_d = pos_q;
              emit_v  = 1'b1;
              emit_r  = '{kind: KIND_ERROR, start: pos_q, len: 16'd1, bad: b, last: 1'b1};
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    res_wr_o.count  = {1'b0, flush_v} + {1'b0, emit_v};
    res_wr_o.first  = flush_v ? flush_r : emit_r;
    res_wr_o.first.last = !(flush_v && emit_v);
    res_wr_o.second = emit_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      cnt_q   <= '0;
      def_q   <= 1'b1;
      ext_q   <= 1'b1;
      pos_q   <= '0;
      bad_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
      def_q   <= def_d;
      ext_q   <= ext_d;
      pos_q   <= pos_d;
      bad_q   <= bad_d;
    end
  end

endmodule

// ----- hdl/klt_out_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one.
// Depends on klt_pkg; OUT_DEPTH is a power of two, at least 4.
module klt_out_fifo
  import klt_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  result_wr_t wr_i,
  output logic       space_o,
  output logic       empty,
  input  logic       pop,
  output result_t    head_o
);

  localparam int unsigned PW = $clog2(OUT_DEPTH);
  localparam int unsigned CW = $clog2(OUT_DEPTH + 1);
  localparam logic [CW-1:0] ROOM_C = CW'(OUT_DEPTH - 2);

  result_t       mem [OUT_DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_p1;
  logic [CW-1:0] count_q, count_d;
  logic          rd_en;

  assign empty   = (count_q == '0);
  assign space_o = (count_q <= ROOM_C);
  assign head_o  = mem[rptr_q];
  assign rd_en   = pop && !empty;
  assign wptr_p1 = wptr_q + PW'(1);

  always_comb begin
    wptr_d  = wptr_q + PW'(wr_i.count);
    rptr_d  = rd_en ? rptr_q + PW'(1) : rptr_q;
    count_d = count_q + CW'(wr_i.count) - CW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.count != 2'd0) begin
      mem[wptr_q] <= wr_i.first;
    end
    if (wr_i.count == 2'd2) begin
      mem[wptr_p1] <= wr_i.second;
    end
  end

endmodule

// ----- hdl/keyword_token_lexer.sv -----
// Keyword token lexer top level: front classifier, scanner, result queue.
// Depends on klt_pkg, klt_front, klt_back, klt_out_fifo and the macros header.
//
//   channel  | handshake      | payload
//   ---------+----------------+--------------------------------------------------
//   input    | push / full    | command_i, source_byte_i
//   result   | pop / empty    | token_kind_o, start_offset_o, token_length_o,
//            |                | bad_byte_o, last_of_run_o
//
// One request per cycle enters the input queue and the scanner retires one per
// cycle; a request gives at most two results, written to the result queue at once.
// The scanner stalls while the result queue has fewer than two free slots; the
// input queue fills behind it.
// Reset clears both queues and returns the scanner to idle at offset zero.
`include "keyword_token_lexer_macros.svh"

module keyword_token_lexer
  import klt_pkg::*;
#(
  parameter int unsigned IN_DEPTH  = IN_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        command_i,
  input  logic [7:0]  source_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  token_kind_o,
  output logic [31:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [7:0]  bad_byte_o,
  output logic        last_of_run_o
);

  front_item_t head;
  logic        head_valid;
  logic        head_pop;
  logic        out_space;
  result_wr_t  res_wr;
  result_t     res_head;

  klt_front #(
    .IN_DEPTH(IN_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .source_byte_i(source_byte_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  klt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .head_pop_o  (head_pop),
    .out_space_i (out_space),
    .res_wr_o    (res_wr)
  );

  klt_out_fifo #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_wr),
    .space_o(out_space),
    .empty  (empty),
    .pop    (pop),
    .head_o (res_head)
  );

  assign token_kind_o   = res_head.kind;
  assign start_offset_o = res_head.start;
  assign token_length_o = res_head.len;
  assign bad_byte_o     = res_head.bad;
  assign last_of_run_o  = res_head.last;

  `KTL_ASSERT_NOW(a_eof_shape, !empty && token_kind_o == KIND_EOF, token_length_o == 16'd0 && bad_byte_o == 8'd0, "eof result with nonzero length or bad byte")
  `KTL_ASSERT_NOW(a_bad_only_err, !empty && token_kind_o != KIND_ERROR, bad_byte_o == 8'd0, "bad byte set on a non-error result")
  `KTL_ASSERT_NOW(a_wr_has_room, res_wr.count != 2'd0, out_space, "result written without queue room")
  `KTL_ASSERT_NEXT(a_run_pair, pop && !empty && !last_of_run_o, !empty, "second result of a pair missing")

endmodule
